// ----- hw/rtl/pts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, widths and codes of the page tile splitter.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int CORD_W  = 48;
  localparam int LEN_W   = 47;
  localparam int SPAN_W  = 51;
  localparam int CW      = 54;
  localparam int FIELD_CAP = 8;
  localparam int CFG_W   = 48;
  localparam int IDX_W   = 3;
  localparam int PROD_W  = 57;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_OVERLAP = 2'd1,
    STATUS_CLAMPED = 2'd2
  } status_t;

  localparam logic [IDX_W-1:0] REG_PAPER_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_PAPER_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAP_SCALE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_MARGIN       = 3'd3;
  localparam logic [IDX_W-1:0] REG_OVERLAP      = 3'd4;

  typedef struct packed {
    logic [23:0] a;
    logic [31:0] b;
    logic [23:0] c;
  } mul_req_t;

  function automatic logic signed [CORD_W-1:0] sat48(input logic signed [CW-1:0] v);
    logic sign;
    logic signed [CORD_W-1:0] r;
    sign = v[CW-1];
    if (v[CW-1:CORD_W-1] == {(CW-CORD_W+1){sign}}) begin
      r = v[CORD_W-1:0];
    end else if (sign) begin
      r = {1'b1, {(CORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(CORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/pts_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_in_if
// Object rectangle channel: two opposite corners, signed Q32.16.
// ----------------------------------------------------------------------------
interface pts_in_if;
  logic                valid;
  logic                ready;
  logic signed [47:0]  corner_a_x;
  logic signed [47:0]  corner_a_y;
  logic signed [47:0]  corner_b_x;
  logic signed [47:0]  corner_b_y;

  modport source (output valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                  input ready);
  modport sink   (input valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/pts_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_out_if
// Page rectangle channel: one page of the covering grid per transaction.
// ----------------------------------------------------------------------------
interface pts_out_if;
  logic                valid;
  logic                ready;
  logic signed [47:0]  page_left;
  logic signed [47:0]  page_top;
  logic signed [47:0]  page_right;
  logic signed [47:0]  page_bottom;
  logic [2:0]          column;
  logic [2:0]          row;
  logic                last_page;
  logic [1:0]          status;

  modport source (output valid, page_left, page_top, page_right, page_bottom,
                  column, row, last_page, status, input ready);
  modport sink   (input valid, page_left, page_top, page_right, page_bottom,
                  column, row, last_page, status, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/pts_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_mul
// Shared registered multiply-add: prod = a * b + c, one result per cycle.
// ----------------------------------------------------------------------------
module pts_mul (
  input  wire logic               clk,
  input  wire pts_pkg::mul_req_t  req,
  output logic [pts_pkg::PROD_W-1:0] prod
);

  logic [55:0] p_full;

  assign p_full = req.a * req.b;

  always_ff @(posedge clk) begin
    prod <= {1'b0, p_full} + {{(pts_pkg::PROD_W-24){1'b0}}, req.c};
  end

endmodule
`default_nettype wire

// ----- hw/rtl/page_tile_splitter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_tile_splitter
// Covers one object rectangle with a centred grid of overlapping pages.
// ----------------------------------------------------------------------------
// One rectangle is taken at a time; in_ch.ready is high only while the block
// is idle. Page sizes are formed on a shared 24x32 multiply-add, the check
// state then tests the overlap, and the column and row counts are found by
// stepping the grid extent one page at a time for each axis.
// Pages follow row by row, at one per cycle while the output is not stalled.
// An overlap not below the page width or height yields a single status 1
// result.
// ----------------------------------------------------------------------------
module page_tile_splitter #(
  parameter int MAX_COLUMNS = 8,
  parameter int MAX_ROWS    = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [pts_pkg::IDX_W-1:0]       cfg_index,
  input  wire logic [pts_pkg::CFG_W-1:0]       cfg_data,
  pts_in_if.sink                               in_ch,
  pts_out_if.source                            out_ch
);

  localparam int BX = (MAX_COLUMNS < pts_pkg::FIELD_CAP) ? MAX_COLUMNS : pts_pkg::FIELD_CAP;
  localparam int BY = (MAX_ROWS < pts_pkg::FIELD_CAP) ? MAX_ROWS : pts_pkg::FIELD_CAP;
  localparam logic [2:0] BX_M1 = 3'(BX - 1);
  localparam logic [2:0] BY_M1 = 3'(BY - 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MLO  = 8'b0000_0010,
    S_MHI  = 8'b0000_0100,
    S_MST  = 8'b0000_1000,
    S_CHK  = 8'b0001_0000,
    S_PLAN = 8'b0010_0000,
    S_EMIT = 8'b0100_0000,
    S_ERR  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [23:0]                   paper_width;
  logic [23:0]                   paper_height;
  logic [47:0]                   map_scale;
  logic [pts_pkg::LEN_W-1:0]     margin;
  logic [pts_pkg::LEN_W-1:0]     overlap;

  logic signed [47:0]            lo_x, hi_x, lo_y, hi_y;
  logic [pts_pkg::LEN_W-1:0]     page_w, page_h, step_x, step_y;
  logic [pts_pkg::SPAN_W-1:0]    span_x, span_y, ext;
  logic signed [48:0]            sum_x, sum_y;
  logic [2:0]                    k, ncx, ncy, col, row;
  logic                          axis, clamped;
  logic signed [pts_pkg::CW-1:0] ox, x0, y0;

  logic                          ovalid;
  logic                          ovalid_next;
  logic signed [47:0]            o_left, o_top, o_right, o_bottom;
  logic [2:0]                    o_col, o_row;
  logic                          o_last;
  pts_pkg::status_t              o_status;

  pts_pkg::mul_req_t             mul_req;
  logic [pts_pkg::PROD_W-1:0]    prod;

  logic [23:0]                   paper_sel;
  logic [pts_pkg::SPAN_W-1:0]    cur_span;
  logic [pts_pkg::LEN_W-1:0]     cur_step, len_sat;
  logic [2:0]                    cur_bound;
  logic signed [48:0]            cur_sum;
  logic signed [pts_pkg::CW-1:0] origin;
  logic                          grow, out_free, page_last;
  logic [48:0]                   dx, dy;

  pts_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  always_comb begin
    paper_sel = axis ? paper_height : paper_width;
    mul_req.a = paper_sel;
    mul_req.b = {16'd0, map_scale[15:0]};
    mul_req.c = 24'd0;
    if (state == S_MHI) begin
      mul_req.b = map_scale[47:16];
      mul_req.c = prod[39:16];
    end
    len_sat   = (prod[pts_pkg::PROD_W-1:pts_pkg::LEN_W] != '0) ? pts_pkg::LEN_MAX
                                                               : prod[pts_pkg::LEN_W-1:0];
    cur_span  = axis ? span_y : span_x;
    cur_step  = axis ? step_y : step_x;
    cur_bound = axis ? BY_M1 : BX_M1;
    cur_sum   = axis ? sum_y : sum_x;
    grow      = (k < cur_bound) && (ext < cur_span);
    origin    = (pts_pkg::CW'(cur_sum) - $signed({3'b000, ext})) >>> 1;
    dx        = {hi_x[47], hi_x} - {lo_x[47], lo_x};
    dy        = {hi_y[47], hi_y} - {lo_y[47], lo_y};
    out_free  = !ovalid || out_ch.ready;
    page_last = (col == ncx) && (row == ncy);
    ovalid_next = (ovalid && !out_ch.ready)
                  || (((state == S_EMIT) || (state == S_ERR)) && out_free);
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      paper_width  <= 24'd13763;
      paper_height <= 24'd19464;
      map_scale    <= 48'd65536;
      margin       <= '0;
      overlap      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pts_pkg::REG_PAPER_WIDTH:  paper_width  <= cfg_data[23:0];
        pts_pkg::REG_PAPER_HEIGHT: paper_height <= cfg_data[23:0];
        pts_pkg::REG_MAP_SCALE:    map_scale    <= cfg_data;
        pts_pkg::REG_MARGIN:       margin       <= cfg_data[pts_pkg::LEN_W-1:0];
        pts_pkg::REG_OVERLAP:      overlap      <= cfg_data[pts_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
      axis   <= 1'b0;
    end else begin
      ovalid <= ovalid_next;
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            lo_x    <= (in_ch.corner_a_x < in_ch.corner_b_x) ? in_ch.corner_a_x
                                                             : in_ch.corner_b_x;
            hi_x    <= (in_ch.corner_a_x < in_ch.corner_b_x) ? in_ch.corner_b_x
                                                             : in_ch.corner_a_x;
            lo_y    <= (in_ch.corner_a_y < in_ch.corner_b_y) ? in_ch.corner_a_y
                                                             : in_ch.corner_b_y;
            hi_y    <= (in_ch.corner_a_y < in_ch.corner_b_y) ? in_ch.corner_b_y
                                                             : in_ch.corner_a_y;
            axis    <= 1'b0;
            clamped <= 1'b0;
            state   <= S_MLO;
          end
        end
        S_MLO: state <= S_MHI;
        S_MHI: state <= S_MST;
        S_MST: begin
          if (axis) begin
            page_h <= len_sat;
            axis   <= 1'b0;
            state  <= S_CHK;
          end else begin
            page_w <= len_sat;
            axis   <= 1'b1;
            state  <= S_MLO;
          end
        end
        S_CHK: begin
          step_x <= page_w - overlap;
          step_y <= page_h - overlap;
          span_x <= {3'b000, dx[47:0]} + {3'b000, margin, 1'b0};
          span_y <= {3'b000, dy[47:0]} + {3'b000, margin, 1'b0};
          sum_x  <= {hi_x[47], hi_x} + {lo_x[47], lo_x};
          sum_y  <= {hi_y[47], hi_y} + {lo_y[47], lo_y};
          k      <= '0;
          ext    <= {4'd0, page_w};
          if ((overlap >= page_w) || (overlap >= page_h)) begin
            state <= S_ERR;
          end else begin
            state <= S_PLAN;
          end
        end
        S_PLAN: begin
          if (grow) begin
            ext <= ext + {4'd0, cur_step};
            k   <= k + 3'd1;
          end else begin
            if (ext < cur_span) begin
              clamped <= 1'b1;
            end
            if (axis) begin
              ncy   <= k;
              y0    <= origin;
              x0    <= ox;
              col   <= '0;
              row   <= '0;
              state <= S_EMIT;
            end else begin
              ncx  <= k;
              ox   <= origin;
              axis <= 1'b1;
              k    <= '0;
              ext  <= {4'd0, page_h};
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            o_left   <= pts_pkg::sat48(x0);
            o_top    <= pts_pkg::sat48(y0);
            o_right  <= pts_pkg::sat48(x0 + $signed({7'd0, page_w}));
            o_bottom <= pts_pkg::sat48(y0 + $signed({7'd0, page_h}));
            o_col    <= col;
            o_row    <= row;
            o_last   <= page_last;
            o_status <= clamped ? pts_pkg::STATUS_CLAMPED : pts_pkg::STATUS_OK;
            if (col == ncx) begin
              col <= '0;
              x0  <= ox;
              row <= row + 3'd1;
              y0  <= y0 + $signed({7'd0, step_y});
            end else begin
              col <= col + 3'd1;
              x0  <= x0 + $signed({7'd0, step_x});
            end
            if (page_last) begin
              state <= S_IDLE;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            o_left   <= '0;
            o_top    <= '0;
            o_right  <= '0;
            o_bottom <= '0;
            o_col    <= '0;
            o_row    <= '0;
            o_last   <= 1'b1;
            o_status <= pts_pkg::STATUS_OVERLAP;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready        = (state == S_IDLE);
  assign out_ch.valid       = ovalid;
  assign out_ch.page_left   = o_left;
  assign out_ch.page_top    = o_top;
  assign out_ch.page_right  = o_right;
  assign out_ch.page_bottom = o_bottom;
  assign out_ch.column      = o_col;
  assign out_ch.row         = o_row;
  assign out_ch.last_page   = o_last;
  assign out_ch.status      = o_status;

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (state == S_MLO))
    else $error("accepted rectangle did not start the page size multiply");

  a_overlap_single: assert property (@(posedge clk) disable iff (rst)
    (ovalid && (o_status == pts_pkg::STATUS_OVERLAP)) |-> (o_last && (o_col == 3'd0)
      && (o_row == 3'd0)))
    else $error("overlap error result is not a single zero page");

  a_grid_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> ((col <= ncx) && (row <= ncy) && (ncx <= BX_M1)
      && (ncy <= BY_M1)))
    else $error("page index left the planned grid");

  a_no_busy_ready: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) || (state == S_PLAN)) |-> !in_ch.ready)
    else $error("input ready while a rectangle is in progress");

endmodule
`default_nettype wire

// ----- test/page_tile_splitter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_tile_splitter_tb
// Self-checking bench for the page tile splitter. Rectangles go in on the
// input channel; each transaction is planned by an in-bench page grid model
// and the pages it should yield are queued and compared field by field with
// what the block emits. Covers defaults, overlap rejection, grid clamping,
// coordinate saturation, extreme register settings, random idling on both
// channels and a long output hold-off.
// ----------------------------------------------------------------------------
module page_tile_splitter_tb;

  localparam int MAX_COLUMNS    = 8;
  localparam int MAX_ROWS       = 8;
  localparam int COL_BOUND      = (MAX_COLUMNS < pts_pkg::FIELD_CAP) ? MAX_COLUMNS
                                                                     : pts_pkg::FIELD_CAP;
  localparam int ROW_BOUND      = (MAX_ROWS < pts_pkg::FIELD_CAP) ? MAX_ROWS
                                                                  : pts_pkg::FIELD_CAP;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_CYCLES     = 100;
  localparam int HOLD_OFF       = 400;
  localparam int PHASE_RECTS    = 70;

  localparam logic signed [47:0] P48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] P48_MIN = 48'sh8000_0000_0000;
  localparam longint             C48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint             C48_MIN = -64'sh0000_8000_0000_0000;

  typedef struct {
    logic signed [47:0] ax;
    logic signed [47:0] ay;
    logic signed [47:0] bx;
    logic signed [47:0] by;
  } rect_t;

  typedef struct {
    logic [47:0]      left;
    logic [47:0]      top;
    logic [47:0]      right;
    logic [47:0]      bottom;
    logic [2:0]       col;
    logic [2:0]       row;
    logic             last_pg;
    pts_pkg::status_t status;
  } page_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [pts_pkg::IDX_W-1:0] cfg_index;
  logic [pts_pkg::CFG_W-1:0] cfg_data;

  pts_in_if  in_ch ();
  pts_out_if out_ch ();

  page_tile_splitter #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  logic [23:0] pw_q;
  logic [23:0] ph_q;
  logic [47:0] scale_q;
  logic [46:0] margin_q;
  logic [46:0] overlap_q;

  page_t expected_pages[$];
  int    errors;
  int    rects_sent;
  int    pages_checked;
  int    overlap_seen;
  int    clamped_seen;
  int    settings_count;
  int    send_idle_pct;
  int    recv_stall_pct;
  int    hold_cnt;
  int    idle_cycles;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] t;
    t = rand64();
    return t[47:0];
  endfunction

  function automatic logic [47:0] clip48(input longint v);
    if (v > C48_MAX) begin
      return P48_MAX;
    end
    if (v < C48_MIN) begin
      return P48_MIN;
    end
    return v[47:0];
  endfunction

  function automatic longint page_extent(input logic [23:0] paper, input logic [47:0] scale);
    logic [63:0] whole;
    logic [63:0] frac;
    logic [63:0] v;
    whole = {40'd0, paper} * {32'd0, scale[47:16]};
    frac  = ({40'd0, paper} * {48'd0, scale[15:0]}) >> 16;
    v     = whole + frac;
    if (v > {17'd0, pts_pkg::LEN_MAX}) begin
      v = {17'd0, pts_pkg::LEN_MAX};
    end
    return longint'(v);
  endfunction

  function automatic rect_t mk_rect(input logic signed [47:0] ax, ay, bx, by);
    rect_t r;
    r.ax = ax;
    r.ay = ay;
    r.bx = bx;
    r.by = by;
    return r;
  endfunction

  task automatic plan_axis(input longint p, q, len, step, input int bound,
                           output int count, output longint origin, inout bit clamped);
    longint lo;
    longint hi;
    longint span;
    longint n;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    lo = lo - longint'({17'd0, margin_q});
    hi = hi + longint'({17'd0, margin_q});
    span = hi - lo;
    if (span <= len) begin
      n = 1;
    end else begin
      n = 1 + (span - len + step - 1) / step;
    end
    if (n > bound) begin
      n = bound;
      clamped = 1'b1;
    end
    count  = int'(n);
    origin = (lo + hi - (len + (n - 1) * step)) >>> 1;
  endtask

  task automatic predict_pages(input rect_t r);
    longint w;
    longint h;
    longint ovl;
    longint ox;
    longint oy;
    longint x0;
    longint y0;
    int     nx;
    int     ny;
    bit     clamped;
    page_t  pg;
    w   = page_extent(pw_q, scale_q);
    h   = page_extent(ph_q, scale_q);
    ovl = longint'({17'd0, overlap_q});
    if (ovl >= w || ovl >= h) begin
      pg.left    = '0;
      pg.top     = '0;
      pg.right   = '0;
      pg.bottom  = '0;
      pg.col     = '0;
      pg.row     = '0;
      pg.last_pg = 1'b1;
      pg.status  = pts_pkg::STATUS_OVERLAP;
      expected_pages.push_back(pg);
      return;
    end
    clamped = 1'b0;
    plan_axis(longint'(r.ax), longint'(r.bx), w, w - ovl, COL_BOUND, nx, ox, clamped);
    plan_axis(longint'(r.ay), longint'(r.by), h, h - ovl, ROW_BOUND, ny, oy, clamped);
    for (int j = 0; j < ny; j++) begin
      y0 = oy + j * (h - ovl);
      for (int i = 0; i < nx; i++) begin
        x0 = ox + i * (w - ovl);
        pg.left    = clip48(x0);
        pg.top     = clip48(y0);
        pg.right   = clip48(x0 + w);
        pg.bottom  = clip48(y0 + h);
        pg.col     = 3'(i);
        pg.row     = 3'(j);
        pg.last_pg = (i == nx - 1) && (j == ny - 1);
        pg.status  = clamped ? pts_pkg::STATUS_CLAMPED : pts_pkg::STATUS_OK;
        expected_pages.push_back(pg);
      end
    end
  endtask

  task automatic shaped_axis(input longint len, step, output logic [47:0] p, q);
    longint target;
    longint span;
    longint centre;
    longint lo;
    target = len + longint'($urandom_range(0, 8)) * step - 2 * longint'({17'd0, margin_q});
    case ($urandom_range(3))
      0: span = target;
      1: span = target + 1;
      2: span = target - 1;
      default: span = target - longint'(rand64() % step);
    endcase
    if (span < 0) begin
      span = 0;
    end
    centre = longint'(rand64() >> 20) - (longint'(1) <<< 43);
    lo = centre - span / 2;
    if ($urandom_range(1) == 1) begin
      p = clip48(lo);
      q = clip48(lo + span);
    end else begin
      p = clip48(lo + span);
      q = clip48(lo);
    end
  endtask

  task automatic pick_rect(output rect_t r);
    longint w;
    longint h;
    longint ovl;
    w   = page_extent(pw_q, scale_q);
    h   = page_extent(ph_q, scale_q);
    ovl = longint'({17'd0, overlap_q});
    if ($urandom_range(7) == 0 || ovl >= w || ovl >= h) begin
      r.ax = rand48();
      r.ay = rand48();
      r.bx = rand48();
      r.by = rand48();
    end else begin
      shaped_axis(w, w - ovl, r.ax, r.bx);
      shaped_axis(h, h - ovl, r.ay, r.by);
    end
  endtask

  task automatic send_rect(input rect_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.corner_a_x = r.ax;
    in_ch.corner_a_y = r.ay;
    in_ch.corner_b_x = r.bx;
    in_ch.corner_b_y = r.by;
    do @(posedge clk); while (!in_ch.ready);
    predict_pages(r);
    rects_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input int n);
    rect_t r;
    repeat (n) begin
      pick_rect(r);
      send_rect(r);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (expected_pages.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [pts_pkg::IDX_W-1:0] idx,
                           input logic [pts_pkg::CFG_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      pts_pkg::REG_PAPER_WIDTH:  pw_q      = value[23:0];
      pts_pkg::REG_PAPER_HEIGHT: ph_q      = value[23:0];
      pts_pkg::REG_MAP_SCALE:    scale_q   = value;
      pts_pkg::REG_MARGIN:       margin_q  = value[46:0];
      pts_pkg::REG_OVERLAP:      overlap_q = value[46:0];
      default: ;
    endcase
  endtask

  task automatic program_setting(input logic [23:0] pw, ph, input logic [47:0] scale,
                                 input logic [46:0] mgn, ovl);
    wait_idle();
    write_reg(pts_pkg::REG_PAPER_WIDTH, {24'd0, pw});
    write_reg(pts_pkg::REG_PAPER_HEIGHT, {24'd0, ph});
    write_reg(pts_pkg::REG_MAP_SCALE, scale);
    write_reg(pts_pkg::REG_MARGIN, {1'b0, mgn});
    write_reg(pts_pkg::REG_OVERLAP, {1'b0, ovl});
    settings_count++;
  endtask

  task automatic random_setting();
    logic [23:0] pw;
    logic [23:0] ph;
    logic [47:0] scale;
    longint      w;
    longint      h;
    longint      shorter;
    pw           = 24'($urandom_range(1, 24'hFF_FFFF));
    ph           = 24'($urandom_range(1, 24'hFF_FFFF));
    scale[47:16] = $urandom_range(1, 1 << 20);
    scale[15:0]  = 16'($urandom);
    w            = page_extent(pw, scale);
    h            = page_extent(ph, scale);
    shorter      = (w < h) ? w : h;
    program_setting(pw, ph, scale, 47'(rand64() % (w / 2 + 1)), 47'(rand64() % shorter));
  endtask

  task automatic test_reset_defaults();
    wait_idle();
    send_rect(mk_rect(0, 0, 0, 0));
    send_rect(mk_rect(0, 0, 13763, 19464));
    send_rect(mk_rect(0, 0, 13764, 19465));
    send_rect(mk_rect(-1, -100, -41292, -1));
    send_rect(mk_rect(110104, 155712, 0, 0));
    send_rect(mk_rect(-5, 3, 110100, 155715));
    send_rect(mk_rect(P48_MIN, P48_MIN, P48_MAX, P48_MAX));
    send_rect(mk_rect(P48_MAX, P48_MAX, P48_MAX, P48_MAX));
    send_rect(mk_rect(P48_MIN, P48_MIN, P48_MIN, P48_MIN));
  endtask

  task automatic test_overlap_limit();
    program_setting(24'd13763, 24'd19464, 48'd65536, 47'd0, 47'd13763);
    send_rect(mk_rect(0, 0, 1000, 1000));
    program_setting(24'd13763, 24'd19464, 48'd65536, 47'd0, 47'd13762);
    send_rect(mk_rect(0, 0, 20, 20));
    send_rect(mk_rect(0, 0, 13768, 19466));
    send_rect(mk_rect(-50000, 7, 50000, 9));
    program_setting(24'hFF_FFFF, 24'd19464, 48'd65536, 47'd0, 47'd19464);
    send_rect(mk_rect(3, 4, 5, 6));
    program_setting(24'hFF_FFFF, 24'd19464, 48'd65536, 47'd1000, 47'd19463);
    send_rect(mk_rect(-10, -10, 10, 10));
    program_setting(24'd13763, 24'd19464, 48'd0, 47'd0, 47'd0);
    send_rect(mk_rect(1, 2, 3, 4));
  endtask

  task automatic test_extreme_settings();
    program_setting(24'hFF_FFFF, 24'd1, 48'hFFFF_FFFF_FFFF, pts_pkg::LEN_MAX, 47'd0);
    send_rect(mk_rect(P48_MIN, P48_MIN, P48_MAX, P48_MAX));
    send_rect(mk_rect(0, 0, 0, 0));
    send_random(8);
    program_setting(24'd1, 24'd1, 48'd65536, 47'd0, 47'd0);
    send_rect(mk_rect(0, 0, 0, 0));
    send_rect(mk_rect(0, 0, 7, 7));
    send_rect(mk_rect(1, 1, 0, 0));
    send_random(6);
    program_setting(24'hFF_FFFF, 24'hFF_FFFF, 48'hFFFF_FFFF_FFFF, 47'd0, pts_pkg::LEN_MAX);
    send_random(3);
    program_setting(24'hFF_FFFF, 24'hFF_FFFF, 48'hFFFF_FFFF_FFFF, 47'd0,
                    pts_pkg::LEN_MAX - 1);
    send_random(6);
  endtask

  task automatic test_random_traffic();
    int send_pcts[4];
    int recv_pcts[4];
    send_pcts = '{0, 50, 0, 16};
    recv_pcts = '{0, 0, 50, 16};
    for (int m = 0; m < 4; m++) begin
      random_setting();
      send_idle_pct  = send_pcts[m];
      recv_stall_pct = recv_pcts[m];
      send_random(PHASE_RECTS);
    end
  endtask

  task automatic test_backpressure();
    random_setting();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cnt       = HOLD_OFF;
    send_random(12);
  endtask

  task automatic check_field(input string name, input logic [47:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_pages
    page_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_pages.size() == 0) begin
        $display("%0t: unexpected page, expected none, actual left %h top %h", $time,
                 out_ch.page_left, out_ch.page_top);
        errors++;
      end else begin
        want = expected_pages.pop_front();
        check_field("page_left", want.left, out_ch.page_left);
        check_field("page_top", want.top, out_ch.page_top);
        check_field("page_right", want.right, out_ch.page_right);
        check_field("page_bottom", want.bottom, out_ch.page_bottom);
        check_field("column", 48'(want.col), 48'(out_ch.column));
        check_field("row", 48'(want.row), 48'(out_ch.row));
        check_field("last_page", 48'(want.last_pg), 48'(out_ch.last_page));
        check_field("status", 48'(want.status), 48'(out_ch.status));
        pages_checked++;
        if (want.status == pts_pkg::STATUS_OVERLAP) begin
          overlap_seen++;
        end
        if (want.status == pts_pkg::STATUS_CLAMPED) begin
          clamped_seen++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d pages outstanding", $time,
               idle_cycles, expected_pages.size());
      $display("page_tile_splitter_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = pts_pkg::REG_PAPER_WIDTH;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.corner_a_x = '0;
    in_ch.corner_a_y = '0;
    in_ch.corner_b_x = '0;
    in_ch.corner_b_y = '0;
    out_ch.ready     = 1'b0;
    pw_q             = 24'd13763;
    ph_q             = 24'd19464;
    scale_q          = 48'd65536;
    margin_q         = '0;
    overlap_q        = '0;
    errors           = 0;
    rects_sent       = 0;
    pages_checked    = 0;
    overlap_seen     = 0;
    clamped_seen     = 0;
    settings_count   = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_cnt         = 0;
    idle_cycles      = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_overlap_limit();
    test_extreme_settings();
    test_random_traffic();
    test_backpressure();

    wait_idle();
    repeat (END_CYCLES) @(negedge clk);
    if (expected_pages.size() != 0) begin
      $display("%0t: %0d pages expected but never emitted", $time, expected_pages.size());
      errors++;
    end
    $display("Sent %0d rectangles over %0d register settings; checked %0d pages",
             rects_sent, settings_count, pages_checked);
    $display("(%0d clamped, %0d overlap rejections), %0d mismatches", clamped_seen,
             overlap_seen, errors);
    if (errors == 0) begin
      $display("page_tile_splitter_tb: PASS");
    end else begin
      $display("page_tile_splitter_tb: FAIL");
    end
    $finish;
  end

endmodule
